FILE: design/ist_pkg.sv
// Shared constants, codes and control/status bundles for the integer set table.
package ist_pkg;

   // Store geometry
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 5;

   // Operation codes; the spare code behaves as a membership test
   localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture a new beat and rewind the scan
      logic scan;     // step the lookup over the store
      logic fetch;    // read the last valid entry
      logic finish;   // apply the update and emit the result
   } ist_ctrl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic hit;        // value matched a valid entry
      logic miss;       // scan passed all valid entries without a match
      logic op_remove;  // captured beat is a remove
   } ist_stat_type;

endpackage

FILE: design/ist_ctrl.sv
// Controller state machine that sequences lookup, fetch and update.
module ist_ctrl
   import ist_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ist_stat_type stat,
   output logic         busy,
   output ist_ctrl_type ctrl
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_FETCH  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.hit && stat.op_remove) begin
               state_in = S_FETCH;
            end else if (stat.hit || stat.miss) begin
               state_in = S_FINISH;
            end
         end
         S_FETCH: begin
            ctrl.fetch = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            ctrl.finish = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // An accepted beat always starts a scan
   a_start_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SCAN))
      else $error("accepted beat did not enter scan");

   // A remove that hit must fetch the last entry before finishing
   a_remove_fetch: assert property (@(posedge clock) disable iff (reset)
      (ctrl.scan && stat.hit && stat.op_remove) |=> ctrl.fetch)
      else $error("remove hit skipped the fetch of the last entry");

endmodule

FILE: design/ist_dp.sv
// Datapath: element store, count, lookup scan, update and result registers.
module ist_dp
   import ist_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ist_ctrl_type         ctrl,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic signed [VAL_W-1:0] req_value,
   output ist_stat_type         stat,
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_found,
   output logic [SIZE_W-1:0]    rsp_set_size
);

   // Element store
   logic [VAL_W-1:0] mem [CAPACITY];

   logic [CMD_W-1:0]    op_ff;
   logic [VAL_W-1:0]    value_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff;
   logic                pend_vld_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [VAL_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]    slot_ff;
   logic                found_ff;
   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic                rsp_found_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;

   logic             issue_go;
   logic [CNT_W-1:0] last_w;
   logic [IDX_W-1:0] rd_addr;
   logic             full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;

   // Scan control and read address
   assign issue_go = ctrl.scan && (issue_ff < count_ff);
   assign last_w   = count_ff - CNT_W'(1);
   assign rd_addr  = ctrl.fetch ? last_w[IDX_W-1:0] : issue_ff[IDX_W-1:0];
   assign full     = (count_ff >= CNT_W'(CAPACITY));

   assign stat.hit       = pend_vld_ff && (rd_data_ff == value_ff);
   assign stat.miss      = ctrl.scan && !pend_vld_ff && (issue_ff >= count_ff);
   assign stat.op_remove = (op_ff == CMD_REMOVE);

   // Decide the update and the status at finish
   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_data   = value_ff;
      case (op_ff)
         CMD_ADD: begin
            if (found_ff) begin
               status_in = ST_DUPLICATE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = ctrl.finish;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (!found_ff) begin
               status_in = ST_ABSENT;
            end else begin
               wr_en    = ctrl.finish;
               wr_addr  = slot_ff;
               wr_data  = rd_data_ff;
               count_in = last_w;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Capture the beat, track the pending slot, record the match, register the result fields
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff    <= req_cmd;
         value_ff <= req_value;
      end
      if (issue_go) begin
         pend_idx_ff <= issue_ff[IDX_W-1:0];
      end
      if (ctrl.scan && stat.hit) begin
         slot_ff <= pend_idx_ff;
      end
      rsp_status_ff <= status_in;
      rsp_found_ff  <= found_ff;
      rsp_size_ff   <= SIZE_W'(count_in);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         issue_ff      <= '0;
         pend_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.finish;
         pend_vld_ff   <= issue_go;
         if (ctrl.load) begin
            issue_ff <= '0;
            found_ff <= 1'b0;
         end else if (issue_go) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         if (ctrl.scan && stat.hit) begin
            found_ff <= 1'b1;
         end
         if (ctrl.finish) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_set_size = rsp_size_ff;

   // Count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   // Count moves only on a finish
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(ctrl.finish))
      else $error("element count changed outside finish");

   // Every result beat follows a finish
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(ctrl.finish))
      else $error("result beat without finish");

   // A hit always lands on a valid slot
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      stat.hit |-> (CNT_W'(pend_idx_ff) < count_ff))
      else $error("hit on a slot beyond the count");

endmodule

FILE: design/integer_set_table_unit.sv
// Integer set table top: a bounded unsorted set of distinct 32-bit integers.
// The result beat follows a scan of the held elements that stops at the first match; a remove
// hit adds a fetch of the last entry, which is moved into the freed slot.
// Only one beat is handled at a time (busy is high through scan, fetch and finish); the
// scan steps one entry per cycle through the store's single read port.
// Reset clears the count and all control state; store contents are left as they are.
module integer_set_table_unit
   import ist_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_strobe,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_found,
   output logic [SIZE_W-1:0]       rsp_set_size
);

   ist_ctrl_type ctrl;
   ist_stat_type stat;

   // Sequencer
   ist_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // Store, scan and result registers
   ist_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .stat         (stat),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_set_size (rsp_set_size)
   );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the integer set table: directed and random add/remove/lookup.
module tb;
   import ist_pkg::*;

   // Spare operation code, handled by the block as a membership test
   localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
   localparam int               CYCLE_LIMIT = 400000;
   localparam int               DRAIN_WAIT  = 30;
   localparam int               RANDOM_BEATS = 750;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [SIZE_W-1:0]   set_size;
   } set_result_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CMD_W-1:0]        req_cmd;
   logic signed [VAL_W-1:0] req_value;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_found;
   logic [SIZE_W-1:0]       rsp_set_size;

   // Shadow copy of the set held by the block
   logic [VAL_W-1:0] shadow_elems [CAPACITY];
   int               shadow_count;

   set_result_type expected_results [$];
   set_result_type head_result;
   logic [VAL_W-1:0] value_pool [24];

   bit no_idle;
   int beats_sent;
   int results_checked;
   int fail_count;
   int cycle_count;
   int status_seen [4];

   integer_set_table_unit dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_set_size (rsp_set_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow set and return the result it must produce
   function automatic set_result_type apply_set_op(input logic [CMD_W-1:0] cmd,
                                                   input logic [VAL_W-1:0] value);
      set_result_type res;
      int             slot;
      slot = shadow_count;
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_elems[i] == value && slot == shadow_count) slot = i;
      end
      res.found  = (slot < shadow_count);
      res.status = ST_DONE;
      if (cmd == CMD_ADD) begin
         if (res.found) begin
            res.status = ST_DUPLICATE;
         end else if (shadow_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            shadow_elems[shadow_count] = value;
            shadow_count++;
         end
      end else if (cmd == CMD_REMOVE) begin
         if (!res.found) begin
            res.status = ST_ABSENT;
         end else begin
            shadow_elems[slot] = shadow_elems[shadow_count-1];
            shadow_count--;
         end
      end
      res.set_size = shadow_count[SIZE_W-1:0];
      return res;
   endfunction

   // Send one beat after a random gap (none when no_idle is set), then record what it must return
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(apply_set_op(cmd, value));
      beats_sent++;
   endtask

   task automatic report_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            head_result = expected_results.pop_front();
            report_field("status", head_result.status, rsp_status);
            report_field("found", head_result.found, rsp_found);
            report_field("set_size", head_result.set_size, rsp_set_size);
            status_seen[rsp_status]++;
            results_checked++;
         end
      end
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** integer_set_table_unit: FAILED **");
      $finish;
   end

   // Lookups and removes on an empty set
   task automatic test_empty_set();
      send_beat(CMD_CONTAINS, 32'd5);
      send_beat(CMD_REMOVE, 32'd5);
      send_beat(CMD_SPARE, 32'd0);
   endtask

   // Extreme values, duplicates, removal from the middle and from the end
   task automatic test_extreme_values();
      send_beat(CMD_ADD, 32'h8000_0000);
      send_beat(CMD_ADD, 32'h7FFF_FFFF);
      send_beat(CMD_ADD, 32'h0000_0000);
      send_beat(CMD_ADD, 32'hFFFF_FFFF);
      send_beat(CMD_ADD, 32'h7FFF_FFFF);
      send_beat(CMD_SPARE, 32'h8000_0000);
      send_beat(CMD_REMOVE, 32'h0000_0000);
      send_beat(CMD_CONTAINS, 32'hFFFF_FFFF);
      send_beat(CMD_REMOVE, 32'hFFFF_FFFF);
      send_beat(CMD_REMOVE, 32'h0000_0000);
   endtask

   // Fill the store, overflow it, and check that a duplicate wins over full
   task automatic test_fill_to_capacity();
      for (int i = 1; i <= CAPACITY - 2; i++) send_beat(CMD_ADD, i * 32'h0101_0101);
      send_beat(CMD_ADD, 32'h1234_5678);
      send_beat(CMD_ADD, 32'h8000_0000);
      send_beat(CMD_REMOVE, 32'h8000_0000);
      send_beat(CMD_CONTAINS, (CAPACITY - 2) * 32'h0101_0101);
   endtask

   // Pick a value: mostly held or pooled ones so lookups hit, some fully random
   function automatic logic [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4 && shadow_count > 0) return shadow_elems[$urandom_range(0, shadow_count - 1)];
      if (r < 8) return value_pool[$urandom_range(0, 23)];
      return $urandom;
   endfunction

   // Random traffic in chunks that push the set toward full or toward empty
   task automatic test_random_traffic();
      int               add_pct;
      int               r;
      logic [CMD_W-1:0] cmd;
      for (int i = 0; i < 20; i++) value_pool[i + 4] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: add_pct = 20;
               1: add_pct = 50;
               default: add_pct = 85;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 4) cmd = CMD_SPARE;
         else if (r < 4 + add_pct) cmd = CMD_ADD;
         else if (r % 2) cmd = CMD_REMOVE;
         else cmd = CMD_CONTAINS;
         send_beat(cmd, pick_value());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_cmd      = CMD_ADD;
      req_value    = '0;
      no_idle      = 1'b0;
      beats_sent   = 0;
      results_checked = 0;
      fail_count   = 0;
      shadow_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_set();
      test_extreme_values();
      test_fill_to_capacity();
      test_random_traffic();

      // Drop start and drain outstanding results
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d operations and checked %0d results over %0d cycles.",
               beats_sent, results_checked, cycle_count);
      $display("Status mix: done %0d, duplicate %0d, absent %0d, full %0d.",
               status_seen[ST_DONE], status_seen[ST_DUPLICATE],
               status_seen[ST_ABSENT], status_seen[ST_FULL]);
      if (fail_count == 0) begin
         $display("** integer_set_table_unit: PASSED **");
      end else begin
         $display("** integer_set_table_unit: FAILED **");
      end
      $finish;
   end

endmodule
